[src/ptd_pkg.sv]
// Shared types, constants and codes of the pixel tone and block dither unit.
package ptd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COORD_W    = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 11;
   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = 3 * CHAN_W;
   localparam int SUM_W      = CHAN_W + 2;

   localparam logic [SIZE_W-1:0] MAX_WIDTH_SZ  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_HEIGHT_SZ = SIZE_W'(MAX_HEIGHT);

   localparam logic [SUM_W-1:0] BW_LIMIT  = SUM_W'(383);
   localparam logic [CHAN_W-1:0] BIN_LIMIT = CHAN_W'(128);
   localparam logic [SUM_W-1:0] DTH_A     = SUM_W'(128);
   localparam logic [SUM_W-1:0] DTH_B     = SUM_W'(383);
   localparam logic [SUM_W-1:0] DTH_C     = SUM_W'(638);
   localparam logic [SUM_W-1:0] DTH_D     = SUM_W'(893);

   // floor(x/3) == (x*683) >> 11 for every x up to 766.
   localparam int RECIP_W     = 10;
   localparam int RECIP_SHIFT = 11;
   localparam logic [RECIP_W-1:0] RECIP_THIRD = RECIP_W'(683);

   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = PTR_W + 1;
   localparam int RUN_MAX    = 4;
   localparam int RUN_W      = 3;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   typedef enum logic [1:0] {
      MODE_GREY   = 2'd0,
      MODE_BW     = 2'd1,
      MODE_BIN    = 2'd2,
      MODE_DITHER = 2'd3
   } mode_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  out_red;
      logic [CHAN_W-1:0]  out_green;
      logic [CHAN_W-1:0]  out_blue;
      logic [COORD_W-1:0] out_column;
      logic [COORD_W-1:0] out_row;
      logic               last_of_run;
   } result_type;

   // One accepted request on its way to the tone stage.
   typedef struct packed {
      mode_type           mode;
      pixel_type          px;
      pixel_type          held;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [RUN_W-1:0]   n;
   } stage_type;

endpackage

[src/ptd_col_store.sv]
// Column store: one write port and two registered read ports.
module ptd_col_store (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ptd_pkg::COORD_W-1:0]    wr_addr,
   input  ptd_pkg::pixel_type             wr_data,
   input  logic [ptd_pkg::COORD_W-1:0]    rd_addr_a,
   input  logic [ptd_pkg::COORD_W-1:0]    rd_addr_b,
   output ptd_pkg::pixel_type             rd_data_a,
   output ptd_pkg::pixel_type             rd_data_b
);
   import ptd_pkg::*;

   pixel_type mem [MAX_HEIGHT];
   pixel_type rd_a_ff;
   pixel_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[src/ptd_tone.sv]
// Tone stage: grey, black/white, binarize and 2x2 block dither results.
module ptd_tone (
   input  ptd_pkg::stage_type                 stage,
   input  ptd_pkg::pixel_type                 top_left,
   input  ptd_pkg::pixel_type                 bottom_left,
   output ptd_pkg::result_type [3:0]          res,
   output logic [ptd_pkg::RUN_W-1:0]          res_n
);
   import ptd_pkg::*;

   logic [SUM_W-1:0]            grey_sum;
   logic [RECIP_W+SUM_W-1:0]    grey_prod;
   logic [CHAN_W-1:0]           grey;
   logic                        bw;
   logic [2:0][SUM_W-1:0]       blk_sum;
   logic [CHAN_W-1:0]           bit_r [4];
   logic [CHAN_W-1:0]           bit_g [4];
   logic [CHAN_W-1:0]           bit_b [4];
   logic [SUM_W-1:0]            thr [4];
   logic [COORD_W-1:0]          col_even;
   logic [COORD_W-1:0]          row_even;

   always_comb begin
      grey_sum  = SUM_W'(stage.px.red) + SUM_W'(stage.px.green)
                + SUM_W'(stage.px.blue) + SUM_W'(1);
      grey_prod = (RECIP_W+SUM_W)'(grey_sum) * (RECIP_W+SUM_W)'(RECIP_THIRD);
      grey      = CHAN_W'(grey_prod >> RECIP_SHIFT);
      bw        = (grey_sum - SUM_W'(1)) >= BW_LIMIT;
   end

   // Each channel of the block sums its four pixels.
   always_comb begin
      blk_sum[0] = SUM_W'(top_left.red) + SUM_W'(bottom_left.red)
                 + SUM_W'(stage.held.red) + SUM_W'(stage.px.red);
      blk_sum[1] = SUM_W'(top_left.green) + SUM_W'(bottom_left.green)
                 + SUM_W'(stage.held.green) + SUM_W'(stage.px.green);
      blk_sum[2] = SUM_W'(top_left.blue) + SUM_W'(bottom_left.blue)
                 + SUM_W'(stage.held.blue) + SUM_W'(stage.px.blue);
   end

   // Results go out top-left, bottom-left, top-right, bottom-right.
   assign thr[0] = DTH_A;
   assign thr[1] = DTH_C;
   assign thr[2] = DTH_D;
   assign thr[3] = DTH_B;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         bit_r[k] = CHAN_W'(blk_sum[0] >= thr[k]);
         bit_g[k] = CHAN_W'(blk_sum[1] >= thr[k]);
         bit_b[k] = CHAN_W'(blk_sum[2] >= thr[k]);
      end
   end

   assign col_even = {stage.col[COORD_W-1:1], 1'b0};
   assign row_even = {stage.row[COORD_W-1:1], 1'b0};

   always_comb begin
      res = '0;
      for (int k = 0; k < 4; k++) begin
         res[k].out_red     = bit_r[k];
         res[k].out_green   = bit_g[k];
         res[k].out_blue    = bit_b[k];
         res[k].out_column  = (k < 2) ? col_even : stage.col;
         res[k].out_row     = (k == 0 || k == 2) ? row_even : stage.row;
         res[k].last_of_run = (k == 3);
      end
      case (stage.mode)
         MODE_GREY: begin
            res[0].out_red   = grey;
            res[0].out_green = grey;
            res[0].out_blue  = grey;
         end
         MODE_BW: begin
            res[0].out_red   = CHAN_W'(bw);
            res[0].out_green = CHAN_W'(bw);
            res[0].out_blue  = CHAN_W'(bw);
         end
         MODE_BIN: begin
            res[0].out_red   = CHAN_W'(stage.px.red >= BIN_LIMIT);
            res[0].out_green = CHAN_W'(stage.px.green >= BIN_LIMIT);
            res[0].out_blue  = CHAN_W'(stage.px.blue >= BIN_LIMIT);
         end
         default: begin
         end
      endcase
      if (stage.mode != MODE_DITHER) begin
         res[0].out_column  = stage.col;
         res[0].out_row     = stage.row;
         res[0].last_of_run = 1'b1;
      end
   end

   assign res_n = stage.n;

endmodule

[src/ptd_emit.sv]
// Result queue: takes up to four results a cycle, hands out one a cycle while rsp_stall is low.
module ptd_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  ptd_pkg::result_type [3:0]         push_res,
   input  logic [ptd_pkg::RUN_W-1:0]         push_n,
   output logic [ptd_pkg::CNT_W-1:0]         level,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ptd_pkg::result_type               rsp_res
);
   import ptd_pkg::*;

   result_type            fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  pop;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_res   = fifo_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign level     = cnt_ff;

   always_comb begin
      head_in = head_ff + PTR_W'(pop);
      tail_in = tail_ff + PTR_W'(push_n);
      cnt_in  = cnt_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RUN_MAX; k++) begin
         if (RUN_W'(k) < push_n) begin
            fifo_ff[PTR_W'(tail_ff + PTR_W'(k))] <= push_res[k];
         end
      end
   end

endmodule

[src/pixel_tone_and_block_dither_unit.sv]
// Top level of the pixel tone and block dither unit.
// Pixels arrive on the req_ channel, column by column with the row index
// running fastest, and results leave on the rsp_ channel. A request is taken
// at a clock edge where req_valid is high and req_stall is low; a result is
// taken where rsp_valid is high and rsp_stall is low.
// Grey, black/white and binarize modes give one result per request. Dither
// mode gives a run of four results when the bottom-right pixel of a 2x2 block
// arrives and none for the other pixels; last_of_run marks the run's end.
// A taken request is registered in the tone stage, then its results are queued.
// A request enters every cycle as long as the result queue (eight entries)
// has room for what is already in flight. The rsp_ channel gives at most one
// result per cycle, so in dither mode the odd columns are paced by the rsp_
// channel and the even columns, which give no results, run at one per cycle;
// a whole frame averages one result per request.
// The previous even column lives in a 1024-entry store with one write port
// and two read ports; it is written only in even columns and blocks use what
// it reads only in odd ones, so the two never touch the same entry in flight.
// A stalled receiver fills the queue, and req_stall then holds off new pixels
// without losing or reordering results. Synchronous reset empties the queue,
// zeroes the counters and held pixel, and sets mode 0 on a 1024 by 1024 image.
// Configuration writes are to be made only while the block is idle.
module pixel_tone_and_block_dither_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [ptd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ptd_pkg::SIZE_W-1:0]        csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ptd_pkg::CHAN_W-1:0]        req_red,
   input  logic [ptd_pkg::CHAN_W-1:0]        req_green,
   input  logic [ptd_pkg::CHAN_W-1:0]        req_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ptd_pkg::CHAN_W-1:0]        rsp_out_red,
   output logic [ptd_pkg::CHAN_W-1:0]        rsp_out_green,
   output logic [ptd_pkg::CHAN_W-1:0]        rsp_out_blue,
   output logic [ptd_pkg::COORD_W-1:0]       rsp_out_column,
   output logic [ptd_pkg::COORD_W-1:0]       rsp_out_row,
   output logic                              rsp_last_of_run
);
   import ptd_pkg::*;

   // Clamp a written size into 1..max.
   function automatic logic [SIZE_W-1:0] limit_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] max);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > max) begin
         r = max;
      end
      return r;
   endfunction

   mode_type            mode_ff;
   logic [SIZE_W-1:0]   width_ff;
   logic [SIZE_W-1:0]   height_ff;
   logic [COORD_W-1:0]  col_ff, col_in;
   logic [COORD_W-1:0]  row_ff, row_in;
   pixel_type           held_ff;
   stage_type           stage_ff, stage_in;
   pixel_type           px;
   logic                accept;
   logic [RUN_W-1:0]    n_new;
   logic [CNT_W+1:0]    need;
   logic [CNT_W-1:0]    level;
   logic [SIZE_W-1:0]   row_next;
   logic [SIZE_W-1:0]   col_next;
   pixel_type           top_left;
   pixel_type           bottom_left;
   result_type [3:0]    tone_res;
   logic [RUN_W-1:0]    tone_n;
   result_type          rsp_res;

   assign px = '{red: req_red, green: req_green, blue: req_blue};

   // Results this pixel will cause, known from the mode and the position alone.
   always_comb begin
      if (mode_ff != MODE_DITHER) begin
         n_new = RUN_W'(1);
      end else if (col_ff[0] && row_ff[0]) begin
         n_new = RUN_W'(RUN_MAX);
      end else begin
         n_new = '0;
      end
   end

   // Room is counted for the queued results, those of the request in the tone
   // stage and those of the new one; pops in this cycle are left out, to be safe.
   assign need      = (CNT_W+2)'(level) + (CNT_W+2)'(stage_ff.n) + (CNT_W+2)'(n_new);
   assign req_stall = need > (CNT_W+2)'(FIFO_DEPTH);
   assign accept    = req_valid && !req_stall;

   // Position counters: the row wraps at the height, then the column steps.
   always_comb begin
      row_next = SIZE_W'(row_ff) + SIZE_W'(1);
      col_next = SIZE_W'(col_ff) + SIZE_W'(1);
      row_in   = row_ff;
      col_in   = col_ff;
      if (accept) begin
         if (row_next >= height_ff) begin
            row_in = '0;
            col_in = (col_next >= width_ff) ? '0 : COORD_W'(col_next);
         end else begin
            row_in = COORD_W'(row_next);
         end
      end
   end

   always_comb begin
      stage_in      = stage_ff;
      stage_in.n    = '0;
      if (accept) begin
         stage_in.mode = mode_ff;
         stage_in.px   = px;
         stage_in.held = held_ff;
         stage_in.col  = col_ff;
         stage_in.row  = row_ff;
         stage_in.n    = n_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_GREY;
         width_ff  <= MAX_WIDTH_SZ;
         height_ff <= MAX_HEIGHT_SZ;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= mode_type'(csr_wdata[1:0]);
            CSR_WIDTH:  width_ff  <= limit_size(csr_wdata, MAX_WIDTH_SZ);
            CSR_HEIGHT: height_ff <= limit_size(csr_wdata, MAX_HEIGHT_SZ);
            default: begin
            end
         endcase
      end
   end

   // The stage payload needs no reset; only its result count does.
   always_ff @(posedge clock) begin
      stage_ff.mode <= stage_in.mode;
      stage_ff.px   <= stage_in.px;
      stage_ff.held <= stage_in.held;
      stage_ff.col  <= stage_in.col;
      stage_ff.row  <= stage_in.row;
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         held_ff    <= '0;
         stage_ff.n <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         stage_ff.n <= stage_in.n;
         if (accept) begin
            held_ff <= px;
         end
      end
   end

   // Even columns are written; a block's left pixels are read from the
   // even and odd row entries of the current block.
   ptd_col_store u_store (
      .clock     (clock),
      .wr_en     (accept && !col_ff[0]),
      .wr_addr   (row_ff),
      .wr_data   (px),
      .rd_addr_a ({row_ff[COORD_W-1:1], 1'b0}),
      .rd_addr_b ({row_ff[COORD_W-1:1], 1'b1}),
      .rd_data_a (top_left),
      .rd_data_b (bottom_left)
   );

   ptd_tone u_tone (
      .stage       (stage_ff),
      .top_left    (top_left),
      .bottom_left (bottom_left),
      .res         (tone_res),
      .res_n       (tone_n)
   );

   ptd_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .push_res  (tone_res),
      .push_n    (tone_n),
      .level     (level),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_out_red     = rsp_res.out_red;
   assign rsp_out_green   = rsp_res.out_green;
   assign rsp_out_blue    = rsp_res.out_blue;
   assign rsp_out_column  = rsp_res.out_column;
   assign rsp_out_row     = rsp_res.out_row;
   assign rsp_last_of_run = rsp_res.last_of_run;

endmodule

[src/ptd_checker.sv]
// Port checks of the pixel tone and block dither unit, bound to the top level.
module ptd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [ptd_pkg::CHAN_W-1:0]        rsp_out_red,
   input logic [ptd_pkg::CHAN_W-1:0]        rsp_out_green,
   input logic [ptd_pkg::CHAN_W-1:0]        rsp_out_blue,
   input logic [ptd_pkg::COORD_W-1:0]       rsp_out_column,
   input logic [ptd_pkg::COORD_W-1:0]       rsp_out_row,
   input logic                              rsp_last_of_run
);
   import ptd_pkg::*;

   // A stalled result keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_red)
         && $stable(rsp_out_green) && $stable(rsp_out_blue)
         && $stable(rsp_out_column) && $stable(rsp_out_row)
         && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // The queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

   // A dither run is queued as a whole, so its next result is ready at once.
   a_run_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("dither run broken");

   // Dither results other than the last of a run are one-bit pixels.
   a_run_binary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_out_red[CHAN_W-1:1] == '0
         && rsp_out_green[CHAN_W-1:1] == '0 && rsp_out_blue[CHAN_W-1:1] == '0)
      else $error("dither result not binary");

endmodule

bind pixel_tone_and_block_dither_unit ptd_checker u_ptd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_red     (rsp_out_red),
   .rsp_out_green   (rsp_out_green),
   .rsp_out_blue    (rsp_out_blue),
   .rsp_out_column  (rsp_out_column),
   .rsp_out_row     (rsp_out_row),
   .rsp_last_of_run (rsp_last_of_run)
);
